// ----- hw/rtl/gmvn_pkg.sv -----
// gmvn_pkg: shared constants and types for the grid mesh vertex normal block.
// No dependencies; imported by gmvn_norm and grid_mesh_vertex_normals.
package gmvn_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUM_ROWS    = 2'd0;
  localparam logic [1:0] CFG_NUM_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_DEGEN_LIMIT = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NROWS_W    = 11;
  localparam int NCOLS_W    = 6;
  localparam int LIMIT_W    = 16;
  localparam int VIDX_W     = 15;
  localparam int NORM_W     = 16;

  // Normalizer datapath: magnitudes scaled into [2^19, 2^20)
  localparam int MAG_W = 20;
  localparam int SQ_W  = 42;   // sum of three 20-bit squares
  localparam int LEN_W = 21;   // isqrt of SQ_W bits
  localparam int REM_W = 38;   // dividend m*65536 + len
  localparam int Q_W   = 17;
  localparam int QB_W  = 5;    // quotient bit counter
  localparam int SQRT_STEPS = 21;
  localparam logic [Q_W-1:0] POS_MAX = 17'd32767;
  localparam logic [Q_W-1:0] NEG_MAX = 17'd32768;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } norm_res_t;

endpackage

// ----- hw/rtl/gmvn_norm.sv -----
// gmvn_norm: iterative normalizer, accumulator sum to Q1.15 unit normal.
// Uses gmvn_pkg; one multiplier, bit-pair square root and restoring divider.
module gmvn_norm
  import gmvn_pkg::*;
#(
  parameter int ACC_W = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] sum_x,
  input  logic signed [ACC_W-1:0] sum_y,
  input  logic signed [ACC_W-1:0] sum_z,
  input  logic [LIMIT_W-1:0]      limit,
  output logic                    done,
  output norm_res_t               res
);

  typedef enum logic [8:0] {
    N_IDLE  = 9'b000000001,
    N_CHK   = 9'b000000010,
    N_DSQ   = 9'b000000100,
    N_SCL   = 9'b000001000,
    N_SQ    = 9'b000010000,
    N_SQRT  = 9'b000100000,
    N_DPREP = 9'b001000000,
    N_DIV   = 9'b010000000,
    N_DONE  = 9'b100000000
  } nstate_t;

  nstate_t            st_r;
  logic [ACC_W-1:0]   m_r [3];
  logic [2:0]         neg_r;
  logic [1:0]         mcnt_r;
  logic [SQ_W-1:0]    acc_r;
  logic [2*MAG_W-1:0] prod_r;
  logic [SQ_W-1:0]    v_r, root_r, bit_r;
  logic [4:0]         scnt_r;
  logic [LEN_W-1:0]   len_r;
  logic [1:0]         ci_r;
  logic [QB_W-1:0]    qb_r;
  logic [REM_W-1:0]   rem_r;
  logic [Q_W-1:0]     q_r;

  logic [ACC_W-1:0]   mx, msel, mci;
  logic [SQ_W-1:0]    acc_sum, root_t, root_nxt;
  logic [REM_W-1:0]   div_t;
  logic               ge;
  logic [Q_W-1:0]     q_nxt, q_sat;
  logic [NORM_W-1:0]  nv;

  always_comb begin
    mx = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
    case (mcnt_r)
      2'd0:    msel = m_r[0];
      2'd1:    msel = m_r[1];
      default: msel = m_r[2];
    endcase
    case (ci_r)
      2'd0:    mci = m_r[0];
      2'd1:    mci = m_r[1];
      default: mci = m_r[2];
    endcase
    acc_sum  = ((mcnt_r == 2'd1) ? '0 : acc_r) + SQ_W'(prod_r);
    root_t   = root_r + bit_r;
    root_nxt = (v_r >= root_t) ? ((root_r >> 1) + bit_r) : (root_r >> 1);
    div_t    = REM_W'({len_r, 1'b0}) << qb_r;
    ge       = rem_r >= div_t;
    q_nxt    = q_r | (Q_W'(ge) << qb_r);
    if (neg_r[ci_r]) begin
      q_sat = (q_nxt > NEG_MAX) ? NEG_MAX : q_nxt;
      nv    = NORM_W'(17'd0 - q_sat);
    end else begin
      q_sat = (q_nxt > POS_MAX) ? POS_MAX : q_nxt;
      nv    = NORM_W'(q_sat);
    end
  end

  assign done = (st_r == N_DONE);

  // squarer: registered before accumulation
  always_ff @(posedge clk) begin
    prod_r <= msel[MAG_W-1:0] * msel[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      case (st_r)
        N_IDLE: begin
          if (start) begin
            m_r[0] <= sum_x[ACC_W-1] ? ACC_W'(-sum_x) : sum_x;
            m_r[1] <= sum_y[ACC_W-1] ? ACC_W'(-sum_y) : sum_y;
            m_r[2] <= sum_z[ACC_W-1] ? ACC_W'(-sum_z) : sum_z;
            neg_r  <= {sum_z[ACC_W-1], sum_y[ACC_W-1], sum_x[ACC_W-1]};
            st_r   <= N_CHK;
          end
        end
        N_CHK: begin
          mcnt_r <= '0;
          st_r   <= (mx[ACC_W-1:8] == '0) ? N_DSQ : N_SCL;
        end
        N_DSQ: begin
          mcnt_r <= mcnt_r + 2'd1;
          acc_r  <= acc_sum;
          if (mcnt_r == 2'd3) begin
            if (acc_sum <= SQ_W'(limit)) begin
              res  <= '{x: '0, y: '0, z: 16'sd32767};
              st_r <= N_DONE;
            end else begin
              st_r <= N_SCL;
            end
          end
        end
        N_SCL: begin
          if (mx[ACC_W-1:MAG_W] != '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (mx[ACC_W-1:MAG_W-1] == '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            mcnt_r <= '0;
            st_r   <= N_SQ;
          end
        end
        N_SQ: begin
          mcnt_r <= mcnt_r + 2'd1;
          acc_r  <= acc_sum;
          if (mcnt_r == 2'd3) begin
            v_r    <= acc_sum;
            root_r <= '0;
            bit_r  <= SQ_W'(1) << (SQ_W - 2);
            scnt_r <= '0;
            st_r   <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (v_r >= root_t) v_r <= v_r - root_t;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          scnt_r <= scnt_r + 5'd1;
          if (scnt_r == 5'(SQRT_STEPS - 1)) begin
            len_r <= root_nxt[LEN_W-1:0];
            ci_r  <= '0;
            st_r  <= N_DPREP;
          end
        end
        N_DPREP: begin
          rem_r <= REM_W'({mci[MAG_W-1:0], 16'd0}) + REM_W'(len_r);
          q_r   <= '0;
          qb_r  <= QB_W'(Q_W - 1);
          st_r  <= N_DIV;
        end
        N_DIV: begin
          if (ge) rem_r <= rem_r - div_t;
          q_r  <= q_nxt;
          qb_r <= qb_r - 1'b1;
          if (qb_r == '0) begin
            case (ci_r)
              2'd0:    res.x <= nv;
              2'd1:    res.y <= nv;
              default: res.z <= nv;
            endcase
            ci_r <= ci_r + 2'd1;
            st_r <= (ci_r == 2'd2) ? N_DONE : N_DPREP;
          end
        end
        N_DONE:  st_r <= N_IDLE;
        default: st_r <= N_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/grid_mesh_vertex_normals.sv -----
// grid_mesh_vertex_normals: streaming area-weighted vertex normals of a grid mesh.
// Uses gmvn_pkg and gmvn_norm (iterative normalizer).
//
// Usage: grid points enter row-major on the in_ channel (valid/ready), signed
// Q8.8 x,y,z. Each point that closes a quad updates the two-row accumulator
// store with the cross products of the quad's two triangles, then emits the
// vertex that became complete; the last point of a row also emits the final
// vertex of the row above, and the last point of the mesh flushes the whole
// bottom row, the final normal flagged with out_mesh_done.
// Results leave on the out_ channel as Q1.15 normals with the vertex index,
// through an output register, so a stalled receiver only holds the block when
// the next normal is ready to be loaded.
// Sequence: in_ready drops for the whole of a point's work. A point that
// closes no quad passes through the accept and the advance; one that closes a
// quad adds the reads of three stored points, the 12 products on the shared
// multiplier and 4 accumulator read-modify-writes, plus for each emitted
// normal the normalizer's range scaling, 21-step square root and three
// 17-step divides (skipped when the sum is degenerate), and it stalls
// while the output register waits on the receiver.
// The final point of a mesh emits num_columns+2 normals, num_columns as clamped.
// Reset (synchronous, rst_n low) returns to the top-left of the mesh with all
// sums zero; a cfg_ write to any of the three registers does the same.
// Accumulator entries carry valid bits, so no clearing pass is needed.
module grid_mesh_vertex_normals
  import gmvn_pkg::*;
#(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [VIDX_W-1:0]            out_vertex_index,
  output logic signed [NORM_W-1:0]     out_normal_x,
  output logic signed [NORM_W-1:0]     out_normal_y,
  output logic signed [NORM_W-1:0]     out_normal_z,
  output logic                         out_mesh_done,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CB    = COORD_BITS;
  localparam int PT_W  = 3 * CB;
  localparam int DW    = CB + 1;
  localparam int PW    = 2 * DW;
  localparam int XW    = PW + 1;
  localparam int ACC_W = 2 * CB + 8;
  localparam int SUM_W = 3 * ACC_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LDP  = 10'b0000000010,
    S_XP   = 10'b0000000100,
    S_URD  = 10'b0000001000,
    S_UWR  = 10'b0000010000,
    S_ERD  = 10'b0000100000,
    S_EWT  = 10'b0001000000,
    S_NRM  = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_ADV  = 10'b1000000000
  } state_t;

  // which vertex is being emitted
  typedef enum logic [1:0] {
    EK_PCM1 = 2'd0,   // row above, column c-1
    EK_PC   = 2'd1,   // row above, column c
    EK_CUR  = 2'd2    // current row flush
  } ekind_t;

  state_t              state_r;
  ekind_t              ek_r;
  logic [NROWS_W-1:0]  num_rows_r;
  logic [NCOLS_W-1:0]  num_cols_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [RW-1:0]       r_r;
  logic [CW-1:0]       c_r, j_r;
  logic                cb_r;          // bank of the current row
  logic [VIDX_W-1:0]   base_r;        // r * columns, 15-bit wrap
  logic [DEPTH-1:0]    sval_r;
  logic [1:0]          ld_cnt_r, ucnt_r;
  logic [2:0]          xcnt_r;
  logic                tri_r;
  logic [PT_W-1:0]     pc_r, a_r, b_r, p_r;
  logic signed [PW-1:0]    prod_r, acc_r;
  logic signed [XW-1:0]    n1_r [3];
  logic signed [XW-1:0]    n2_r [3];
  logic signed [ACC_W-1:0] delta_r [3];
  logic [AW-1:0]       waddr_r;
  logic [VIDX_W-1:0]   idx_r;
  logic                done_r;

  logic                out_valid_r, out_done_r;
  logic [VIDX_W-1:0]   out_idx_r;
  norm_res_t           out_res_r;

  // memories
  logic [PT_W-1:0]  pt_mem [DEPTH];
  logic [PT_W-1:0]  pt_rdata_r;
  logic [SUM_W-1:0] sum_mem [DEPTH];
  logic [SUM_W-1:0] sum_rdata_r;
  logic             sum_rvalid_r;

  logic [31:0]      nr32, nc32;
  logic [CW-1:0]    cm1;
  logic             last_col, last_row, in_acc;
  logic [AW-1:0]    pt_raddr, sum_raddr, upd_addr, emit_addr;
  logic [SUM_W-1:0] sum_rd, sum_wdata;
  logic             sum_we;
  logic [PT_W-1:0]  ta, tb;
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz, mul_a, mul_b;
  logic [VIDX_W-1:0] pbase;
  logic             norm_start, norm_done;
  norm_res_t        norm_res;

  // Effective sizes, clamped to the supported range
  always_comb begin
    nr32 = 32'(num_rows_r);
    if (nr32 < 32'd2) nr32 = 32'd2;
    else if (nr32 > 32'(MAX_ROWS)) nr32 = 32'(MAX_ROWS);
    nc32 = 32'(num_cols_r);
    if (nc32 < 32'd2) nc32 = 32'd2;
    else if (nc32 > 32'(MAX_COLUMNS)) nc32 = 32'(MAX_COLUMNS);
  end

  assign cm1      = c_r - 1'b1;
  assign last_col = (32'(c_r) + 32'd1) >= nc32;
  assign last_row = (32'(r_r) + 32'd1) >= nr32;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pbase    = base_r - VIDX_W'(nc32);

  // Point store addresses: {bank, column}
  always_comb begin
    case (ld_cnt_r)
      2'd0:    pt_raddr = {cb_r, cm1};
      2'd1:    pt_raddr = {~cb_r, cm1};
      default: pt_raddr = {~cb_r, c_r};
    endcase
    case (ucnt_r)
      2'd0:    upd_addr = {cb_r, cm1};
      2'd1:    upd_addr = {~cb_r, cm1};
      2'd2:    upd_addr = {cb_r, c_r};
      default: upd_addr = {~cb_r, c_r};
    endcase
    case (ek_r)
      EK_PCM1: emit_addr = {~cb_r, cm1};
      EK_PC:   emit_addr = {~cb_r, c_r};
      default: emit_addr = {cb_r, j_r};
    endcase
    sum_raddr = (state_r == S_URD) ? upd_addr : emit_addr;
  end

  always_ff @(posedge clk) begin
    if (in_acc) pt_mem[{cb_r, c_r}] <= {in_point_z, in_point_y, in_point_x};
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  // Accumulator store; unwritten entries of a row read as zero
  assign sum_rd = sum_rvalid_r ? sum_rdata_r : '0;
  assign sum_we = (state_r == S_UWR);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_wdata[i*ACC_W +: ACC_W] = sum_rd[i*ACC_W +: ACC_W] + delta_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[waddr_r] <= sum_wdata;
    sum_rdata_r <= sum_mem[sum_raddr];
  end

  // Cross product operands: T1 = (cur[c-1], prev[c-1], cur[c]), T2 = (prev[c-1], prev[c], cur[c])
  assign ta = tri_r ? b_r : a_r;
  assign tb = tri_r ? p_r : b_r;
  assign ux = DW'($signed(tb[CB-1:0]))      - DW'($signed(ta[CB-1:0]));
  assign uy = DW'($signed(tb[2*CB-1:CB]))   - DW'($signed(ta[2*CB-1:CB]));
  assign uz = DW'($signed(tb[3*CB-1:2*CB])) - DW'($signed(ta[3*CB-1:2*CB]));
  assign vx = DW'($signed(pc_r[CB-1:0]))      - DW'($signed(ta[CB-1:0]));
  assign vy = DW'($signed(pc_r[2*CB-1:CB]))   - DW'($signed(ta[2*CB-1:CB]));
  assign vz = DW'($signed(pc_r[3*CB-1:2*CB])) - DW'($signed(ta[3*CB-1:2*CB]));

  always_comb begin
    case (xcnt_r)
      3'd0:    begin mul_a = uy; mul_b = vz; end
      3'd1:    begin mul_a = uz; mul_b = vy; end
      3'd2:    begin mul_a = uz; mul_b = vx; end
      3'd3:    begin mul_a = ux; mul_b = vz; end
      3'd4:    begin mul_a = ux; mul_b = vy; end
      default: begin mul_a = uy; mul_b = vx; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign norm_start = (state_r == S_EWT);

  gmvn_norm #(
    .ACC_W (ACC_W)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .sum_x (sum_rd[ACC_W-1:0]),
    .sum_y (sum_rd[2*ACC_W-1:ACC_W]),
    .sum_z (sum_rd[3*ACC_W-1:2*ACC_W]),
    .limit (limit_r),
    .done  (norm_done),
    .res   (norm_res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ek_r        <= EK_PCM1;
      num_rows_r  <= NROWS_W'(2);
      num_cols_r  <= NCOLS_W'(2);
      limit_r     <= '0;
      r_r         <= '0;
      c_r         <= '0;
      j_r         <= '0;
      cb_r        <= 1'b0;
      base_r      <= '0;
      sval_r      <= '0;
      ld_cnt_r    <= '0;
      ucnt_r      <= '0;
      xcnt_r      <= '0;
      tri_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sum_rvalid_r <= 1'b0;
    end else begin
      sum_rvalid_r <= sval_r[sum_raddr];
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pc_r     <= {in_point_z, in_point_y, in_point_x};
            ld_cnt_r <= '0;
            state_r  <= (r_r != '0 && c_r != '0) ? S_LDP : S_ADV;
          end
        end
        S_LDP: begin
          ld_cnt_r <= ld_cnt_r + 2'd1;
          case (ld_cnt_r)
            2'd1:    a_r <= pt_rdata_r;
            2'd2:    b_r <= pt_rdata_r;
            2'd3:    p_r <= pt_rdata_r;
            default: ;
          endcase
          if (ld_cnt_r == 2'd3) begin
            xcnt_r  <= '0;
            tri_r   <= 1'b0;
            state_r <= S_XP;
          end
        end
        S_XP: begin
          // product k issued at step k, consumed at step k+1
          xcnt_r <= xcnt_r + 3'd1;
          if (xcnt_r != 3'd0) begin
            if (xcnt_r[0]) begin
              acc_r <= prod_r;
            end else if (tri_r) begin
              n2_r[xcnt_r[2:1] - 2'd1] <= XW'(acc_r) - XW'(prod_r);
            end else begin
              n1_r[xcnt_r[2:1] - 2'd1] <= XW'(acc_r) - XW'(prod_r);
            end
          end
          if (xcnt_r == 3'd6) begin
            xcnt_r <= '0;
            if (tri_r) begin
              ucnt_r  <= '0;
              state_r <= S_URD;
            end else begin
              tri_r <= 1'b1;
            end
          end
        end
        S_URD: begin
          // cur[c-1]+=n1, prev[c-1]+=n1+n2, cur[c]+=n1+n2, prev[c]+=n2
          waddr_r <= upd_addr;
          for (int i = 0; i < 3; i++) begin
            case (ucnt_r)
              2'd0:    delta_r[i] <= ACC_W'(n1_r[i]);
              2'd3:    delta_r[i] <= ACC_W'(n2_r[i]);
              default: delta_r[i] <= ACC_W'(n1_r[i]) + ACC_W'(n2_r[i]);
            endcase
          end
          state_r <= S_UWR;
        end
        S_UWR: begin
          sval_r[waddr_r] <= 1'b1;
          ucnt_r <= ucnt_r + 2'd1;
          if (ucnt_r == 2'd3) begin
            ek_r    <= EK_PCM1;
            state_r <= S_ERD;
          end else begin
            state_r <= S_URD;
          end
        end
        S_ERD: state_r <= S_EWT;
        S_EWT: begin
          case (ek_r)
            EK_PCM1: idx_r <= pbase + VIDX_W'(cm1);
            EK_PC:   idx_r <= pbase + VIDX_W'(c_r);
            default: idx_r <= base_r + VIDX_W'(j_r);
          endcase
          done_r  <= (ek_r == EK_CUR) && ((32'(j_r) + 32'd1) == nc32);
          state_r <= S_NRM;
        end
        S_NRM: if (norm_done) state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= idx_r;
            out_res_r   <= norm_res;
            out_done_r  <= done_r;
            case (ek_r)
              EK_PCM1: begin
                if (last_col) begin
                  ek_r    <= EK_PC;
                  state_r <= S_ERD;
                end else begin
                  state_r <= S_ADV;
                end
              end
              EK_PC: begin
                if (last_row) begin
                  ek_r    <= EK_CUR;
                  j_r     <= '0;
                  state_r <= S_ERD;
                end else begin
                  state_r <= S_ADV;
                end
              end
              default: begin
                if ((32'(j_r) + 32'd1) < nc32) begin
                  j_r     <= j_r + 1'b1;
                  state_r <= S_ERD;
                end else begin
                  state_r <= S_ADV;
                end
              end
            endcase
          end
        end
        S_ADV: begin
          if (last_col && last_row) begin
            // mesh finished: start over
            r_r    <= '0;
            c_r    <= '0;
            base_r <= '0;
            sval_r <= '0;
          end else if (last_col) begin
            // old previous bank becomes the new, empty current row
            r_r    <= r_r + 1'b1;
            c_r    <= '0;
            base_r <= base_r + VIDX_W'(nc32);
            cb_r   <= ~cb_r;
            for (int k = 0; k < DEPTH; k++) begin
              if (k[CW] != cb_r) sval_r[k] <= 1'b0;
            end
          end else begin
            c_r <= c_r + 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // register write restarts the mesh
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_ROWS:    num_rows_r <= cfg_wdata[NROWS_W-1:0];
          CFG_NUM_COLUMNS: num_cols_r <= cfg_wdata[NCOLS_W-1:0];
          CFG_DEGEN_LIMIT: limit_r    <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
        if (cfg_index == CFG_NUM_ROWS || cfg_index == CFG_NUM_COLUMNS ||
            cfg_index == CFG_DEGEN_LIMIT) begin
          r_r    <= '0;
          c_r    <= '0;
          base_r <= '0;
          sval_r <= '0;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_normal_x     = out_res_r.x;
  assign out_normal_y     = out_res_r.y;
  assign out_normal_z     = out_res_r.z;
  assign out_mesh_done    = out_done_r;

  // One transaction in flight: a point blocks the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input accepted while busy");

  // Normalizer finishes only while the sequencer waits for it
  a_norm_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (state_r == S_NRM))
    else $error("unexpected normalizer completion");

  // End of mesh returns to the first point with empty accumulators
  a_mesh_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV && last_col && last_row) |=>
      (r_r == '0 && c_r == '0 && sval_r == '0))
    else $error("mesh not restarted after flush");

endmodule

// ----- bench/gmvn_normal_checker.sv -----
// gmvn_normal_checker: watches the grid_mesh_vertex_normals channels, predicts
// every vertex normal and compares it with what the block returns.
// Depends on gmvn_pkg for widths, register indexes and the normal type.
module gmvn_normal_checker
  import gmvn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [15:0]       in_point_x,
  input  logic signed [15:0]       in_point_y,
  input  logic signed [15:0]       in_point_z,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [VIDX_W-1:0]        out_vertex_index,
  input  logic signed [NORM_W-1:0] out_normal_x,
  input  logic signed [NORM_W-1:0] out_normal_y,
  input  logic signed [NORM_W-1:0] out_normal_z,
  input  logic                     out_mesh_done,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  output int                       fail_count,
  output int                       pending,
  output int                       normals_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 32;

  typedef struct {
    logic [VIDX_W-1:0] index;
    norm_res_t         n;
    logic              done;
  } vertex_normal_t;

  vertex_normal_t normals_due[$];

  logic [NROWS_W-1:0] rows_reg;
  logic [NCOLS_W-1:0] cols_reg;
  logic [LIMIT_W-1:0] limit_reg;
  longint prev_pt [COLS][3];
  longint cur_pt  [COLS][3];
  longint prev_sum[COLS][3];
  longint cur_sum [COLS][3];
  int     row_pos, col_pos;

  assign pending = normals_due.size();

  function automatic void clear_sums();
    for (int j = 0; j < COLS; j++)
      for (int k = 0; k < 3; k++) begin
        prev_sum[j][k] = 0;
        cur_sum[j][k]  = 0;
      end
  endfunction

  // Unit normal of a raw accumulator, Q1.15, sign kept per component.
  function automatic norm_res_t unit_normal(longint sx, longint sy, longint sz);
    longint    s[3];
    bit [63:0] m[3];
    bit [63:0] mx, sq, len, bitv, q;
    longint    nv[3];
    norm_res_t r;
    s[0] = sx; s[1] = sy; s[2] = sz;
    for (int i = 0; i < 3; i++) m[i] = s[i] < 0 ? -s[i] : s[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx < 256 && m[0]*m[0] + m[1]*m[1] + m[2]*m[2] <= limit_reg) begin
      nv[0] = 0; nv[1] = 0; nv[2] = 32767;
    end else begin
      while (mx >= (64'd1 << 20)) begin
        for (int i = 0; i < 3; i++) m[i] >>= 1;
        mx >>= 1;
      end
      while (mx < (64'd1 << 19)) begin
        for (int i = 0; i < 3; i++) m[i] <<= 1;
        mx <<= 1;
      end
      sq = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
      // bitwise integer square root
      len = 0;
      bitv = 64'd1 << 62;
      while (bitv > sq) bitv >>= 2;
      while (bitv != 0) begin
        if (sq >= len + bitv) begin
          sq  = sq - (len + bitv);
          len = (len >> 1) + bitv;
        end else len >>= 1;
        bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 65536 + len) / (2 * len);
        if (s[i] < 0) begin
          if (q > 32768) q = 32768;
          nv[i] = -longint'(q);
        end else begin
          if (q > 32767) q = 32767;
          nv[i] = longint'(q);
        end
      end
    end
    r.x = nv[0][15:0];
    r.y = nv[1][15:0];
    r.z = nv[2][15:0];
    return r;
  endfunction

  function automatic void queue_normal(longint index, longint sums[3], logic done);
    vertex_normal_t v;
    v.index = index[VIDX_W-1:0];
    v.n     = unit_normal(sums[0], sums[1], sums[2]);
    v.done  = done;
    normals_due.push_back(v);
  endfunction

  // Cross product (B-A)x(C-A) of one triangle, returned in n.
  function automatic void add_triangle(longint a[3], longint b[3], longint c[3],
                                       output longint n[3]);
    longint u[3], w[3];
    for (int k = 0; k < 3; k++) begin
      u[k] = b[k] - a[k];
      w[k] = c[k] - a[k];
    end
    n[0] = u[1]*w[2] - u[2]*w[1];
    n[1] = u[2]*w[0] - u[0]*w[2];
    n[2] = u[0]*w[1] - u[1]*w[0];
  endfunction

  function automatic void take_point(longint px, longint py, longint pz);
    int     nr, nc, r, c;
    longint n[3];
    bit     last_col, last_row;
    nr = rows_reg < 2 ? 2 : (rows_reg > 1024 ? 1024 : rows_reg);
    nc = cols_reg < 2 ? 2 : (cols_reg > COLS ? COLS : cols_reg);
    r = row_pos;
    c = col_pos >= nc ? nc - 1 : col_pos;
    cur_pt[c][0] = px; cur_pt[c][1] = py; cur_pt[c][2] = pz;
    if (r >= 1 && c >= 1) begin
      add_triangle(cur_pt[c-1], prev_pt[c-1], cur_pt[c], n);
      for (int k = 0; k < 3; k++) begin
        cur_sum[c-1][k]  += n[k];
        prev_sum[c-1][k] += n[k];
        cur_sum[c][k]    += n[k];
      end
      add_triangle(prev_pt[c-1], prev_pt[c], cur_pt[c], n);
      for (int k = 0; k < 3; k++) begin
        prev_sum[c-1][k] += n[k];
        prev_sum[c][k]   += n[k];
        cur_sum[c][k]    += n[k];
      end
      queue_normal(longint'(r-1)*nc + (c-1), prev_sum[c-1], 1'b0);
    end
    last_col = c + 1 >= nc;
    last_row = r + 1 >= nr;
    if (last_col && r >= 1) queue_normal(longint'(r-1)*nc + c, prev_sum[c], 1'b0);
    if (last_col && last_row) begin
      // bottom row flush ends the mesh
      for (int j = 0; j < nc; j++)
        queue_normal(longint'(r)*nc + j, cur_sum[j], j + 1 == nc);
      clear_sums();
      row_pos = 0;
      col_pos = 0;
    end else if (last_col) begin
      prev_pt  = cur_pt;
      prev_sum = cur_sum;
      for (int j = 0; j < COLS; j++)
        for (int k = 0; k < 3; k++) cur_sum[j][k] = 0;
      row_pos = r + 1;
      col_pos = 0;
    end else col_pos = c + 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg  <= 2;
      cols_reg  <= 2;
      limit_reg <= 0;
      clear_sums();
      row_pos = 0;
      col_pos = 0;
      normals_due.delete();
      fail_count   <= 0;
      normals_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_ROWS:    rows_reg  <= cfg_wdata[NROWS_W-1:0];
          CFG_NUM_COLUMNS: cols_reg  <= cfg_wdata[NCOLS_W-1:0];
          CFG_DEGEN_LIMIT: limit_reg <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
        if (cfg_index == CFG_NUM_ROWS || cfg_index == CFG_NUM_COLUMNS ||
            cfg_index == CFG_DEGEN_LIMIT) begin
          clear_sums();
          row_pos = 0;
          col_pos = 0;
        end
      end
      if (in_valid && in_ready) take_point(in_point_x, in_point_y, in_point_z);
      if (out_valid && out_ready) begin
        normals_seen <= normals_seen + 1;
        if (normals_due.size() == 0) begin
          $error("unexpected normal, vertex_index %0d", out_vertex_index);
          fail_count <= fail_count + 1;
        end else begin
          automatic vertex_normal_t e = normals_due.pop_front();
          automatic int bad = 0;
          if (out_vertex_index !== e.index) begin
            $error("vertex_index expected %0d actual %0d", e.index, out_vertex_index);
            bad++;
          end
          if (out_normal_x !== e.n.x) begin
            $error("normal_x expected %0d actual %0d", e.n.x, out_normal_x);
            bad++;
          end
          if (out_normal_y !== e.n.y) begin
            $error("normal_y expected %0d actual %0d", e.n.y, out_normal_y);
            bad++;
          end
          if (out_normal_z !== e.n.z) begin
            $error("normal_z expected %0d actual %0d", e.n.z, out_normal_z);
            bad++;
          end
          if (out_mesh_done !== e.done) begin
            $error("mesh_done expected %0d actual %0d", e.done, out_mesh_done);
            bad++;
          end
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

// ----- bench/grid_mesh_vertex_normals_test.sv -----
// grid_mesh_vertex_normals_test: stimulus and verdict for grid_mesh_vertex_normals.
// Depends on gmvn_pkg, the block itself and gmvn_normal_checker.
module grid_mesh_vertex_normals_test;
  import gmvn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VIDX_W-1:0] out_vertex_index;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_mesh_done;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int  fail_count, pending, normals_seen;
  int  points_sent = 0;
  int  settings_used = 0;
  bit  quiet = 1'b0;      // last part of the run: no idling at all
  bit  hold_req = 1'b0;   // asks the receiver for one long hold-off

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  grid_mesh_vertex_normals u_dut (.*);

  gmvn_normal_checker u_check (.*);

  // Receiver: random ready bursts, plus one long hold while points keep coming.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  // One point transaction; valid stays up across back-to-back points.
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
  endtask

  // Sender waits out every pending normal, then the block's tail latency.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Writes all three registers; only called with the block idle.
  task automatic set_mesh(int rows, int cols, int limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_ROWS;
    cfg_wdata <= 16'(rows);
    @(posedge clk);
    cfg_index <= CFG_NUM_COLUMNS;
    cfg_wdata <= 16'(cols);
    @(posedge clk);
    cfg_index <= CFG_DEGEN_LIMIT;
    cfg_wdata <= 16'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random content: mostly full range, some small (near degenerate) points.
  function automatic logic [15:0] coord();
    case ($urandom_range(0, 5))
      0:       return 16'($signed($urandom_range(0, 6)) - 3);
      1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2:       return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int rows, cols, pts, lim;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flat unit quad at reset settings: normal along plus z
    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'd256, 16'd0, 16'd0);
    send_point(16'd0, 16'd256, 16'd0);
    send_point(16'd256, 16'd256, 16'd0);
    drain();
    // coordinate extremes
    set_mesh(2, 2, 0);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000, 16'h7fff);
    send_point(16'h8000, 16'h7fff, 16'h0000);
    send_point(16'h7fff, 16'h7fff, 16'h8000);
    drain();
    // plane x = const: pure x normal, negative side saturates to -32768
    set_mesh(2, 2, 0);
    send_point(16'h0100, 16'h0000, 16'h0000);
    send_point(16'h0100, 16'h0000, 16'h0200);
    send_point(16'h0100, 16'h0200, 16'h0000);
    send_point(16'h0100, 16'h0200, 16'h0200);
    // all zero mesh and tiny triangles under the top limit, clamped sizes
    drain();
    set_mesh(0, 1, 65535);
    repeat (2) send_point(16'd0, 16'd0, 16'd0);
    send_point(16'd0, 16'd3, 16'd0);
    send_point(16'd2, 16'd3, 16'd1);
    drain();
    // widest mesh, column count clamped down from 63
    set_mesh(2, 63, 12345);
    for (int i = 0; i < 64; i++) send_point(coord(), coord(), coord());
    drain();
    // huge row count clamped: partial mesh, then restarted by a write
    set_mesh(2047, 3, 1);
    for (int i = 0; i < 12; i++) send_point(coord(), coord(), coord());
    drain();

    // random meshes; long receiver hold-off in one of them
    while (points_sent < 360) begin
      if (points_sent > 300) quiet = 1'b1;
      rows = $urandom_range(2, 5);
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 6);
      lim  = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
      set_mesh(rows, cols, lim);
      if (settings_used == 10) hold_req = 1'b1;
      rows = rows < 2 ? 2 : rows;
      cols = cols < 2 ? 2 : (cols > 32 ? 32 : cols);
      pts  = rows * cols;
      for (int i = 0; i < pts; i++) send_point(coord(), coord(), coord());
      drain();
    end

    $display("Sent %0d grid points under %0d register settings; %0d normals checked.",
             points_sent, settings_used, normals_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS grid_mesh_vertex_normals");
    end else begin
      $display("FAIL grid_mesh_vertex_normals");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL grid_mesh_vertex_normals");
    $finish;
  end

endmodule
